// File: design/ffn_pkg.sv
// ----------------------------------------------------------------------------
// ffn_pkg
// shared types and the TRI_VERTS constant for the flat face normal generator
// ----------------------------------------------------------------------------
package ffn_pkg;

    localparam int TRI_VERTS = 3;

    // one vertex: position plus pass-through attribute words
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        color;
        logic [31:0]        u;
        logic [31:0]        v;
    } vtx_t;

    // one unit of work for the back end: up to three vertices
    typedef struct packed {
        vtx_t [TRI_VERTS-1:0] vtx;
        logic [1:0]           n;
        logic                 eol;
    } job_t;

endpackage

// File: design/ffn_front.sv
// ----------------------------------------------------------------------------
// ffn_front
// collects vertices into triangles or leftover groups and issues jobs
// ----------------------------------------------------------------------------
module ffn_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ffn_pkg::vtx_t      cur,
    input  logic               end_of_list,
    output logic               push_valid,
    input  logic               push_ready,
    output ffn_pkg::job_t      push_job
);

    logic [1:0]               cnt_reg;
    ffn_pkg::vtx_t [1:0]      held_reg;
    logic                     accept;
    logic                     hold;

    assign in_stall   = !push_ready;
    assign accept     = in_valid && !in_stall;
    assign hold       = (cnt_reg != 2'd2) && !end_of_list;
    assign push_valid = in_valid && !hold;

    always_comb
    begin
        push_job.vtx[0] = (cnt_reg == 2'd0) ? cur : held_reg[0];
        push_job.vtx[1] = (cnt_reg == 2'd1) ? cur : held_reg[1];
        push_job.vtx[2] = cur;
        push_job.n      = cnt_reg + 2'd1;
        push_job.eol    = end_of_list;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (accept)
        begin
            cnt_reg <= hold ? cnt_reg + 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold)
        begin
            held_reg[cnt_reg[0]] <= cur;
        end
    end

endmodule

// File: design/ffn_queue.sv
// ----------------------------------------------------------------------------
// ffn_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module ffn_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ffn_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_take,
    output ffn_pkg::job_t pop_job
);

    ffn_pkg::job_t [1:0] slot_reg;
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          fill_reg;
    logic                push;
    logic                pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_take && pop_valid;
    assign pop_job    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: design/ffn_back.sv
// ----------------------------------------------------------------------------
// ffn_back
// sequenced face normal datapath and vertex emission
// ----------------------------------------------------------------------------
module ffn_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    output logic                job_take,
    input  ffn_pkg::job_t       job,
    output logic                out_valid,
    input  logic                out_stall,
    output ffn_pkg::vtx_t       out_vtx,
    output logic signed [15:0]  normal_x,
    output logic signed [15:0]  normal_y,
    output logic signed [15:0]  normal_z,
    output logic                last_vertex
);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_EDGE = 9'b000000010,
        S_PRE  = 9'b000000100,
        S_MUL  = 9'b000001000,
        S_ABS  = 9'b000010000,
        S_NORM = 9'b000100000,
        S_SQR  = 9'b001000000,
        S_ROOT = 9'b010000000,
        S_DIV  = 9'b100000000
    } state_t;

    // emission rides on the idle state: a separate flag keeps the enum to idle and datapath steps
    state_t              state_reg;
    logic                emit_reg;
    ffn_pkg::job_t       job_reg;

    logic signed [32:0]  ea_reg [3];
    logic signed [32:0]  eb_reg [3];
    logic [29:0]         ma_reg [3];
    logic [29:0]         mb_reg [3];
    logic [2:0]          na_reg;
    logic [2:0]          nb_reg;
    logic [2:0]          step_reg;
    logic [59:0]         prod_reg;
    logic                prod_neg_reg;
    logic [1:0]          prod_sel_reg;
    logic signed [62:0]  c_reg [3];
    logic [61:0]         m_reg [3];
    logic [2:0]          cn_reg;
    logic [61:0]         s_reg;
    logic [61:0]         rt_rem_reg;
    logic [62:0]         rt_r_reg;
    logic [4:0]          rt_k_reg;
    logic [31:0]         len_reg;
    logic [46:0]         dv_rem_reg;
    logic [14:0]         dv_q_reg;
    logic [3:0]          dv_bit_reg;
    logic [1:0]          comp_reg;
    logic signed [15:0]  nrm_reg [3];
    logic [1:0]          em_idx_reg;

    logic [29:0]         op_a;
    logic [29:0]         op_b;
    logic                op_neg;
    logic [1:0]          op_sel;
    logic [61:0]         s_sum;
    logic [61:0]         m_or;
    logic [62:0]         rt_bit;
    logic [62:0]         rt_try;
    logic                rt_ge;
    logic [62:0]         rt_r_next;
    logic [46:0]         dv_d;
    logic                dv_ge;
    logic [14:0]         dv_q_next;
    logic [15:0]         dv_q16;
    logic [32:0]         mag_a [3];
    logic [32:0]         mag_b [3];
    logic [32:0]         or_a;
    logic [32:0]         or_b;
    logic [1:0]          sh_a;
    logic [1:0]          sh_b;
    logic                out_take;

    assign job_take  = (state_reg == S_IDLE) && !emit_reg && job_valid;
    assign out_valid = emit_reg;
    assign out_take  = emit_reg && !out_stall;

    assign out_vtx     = job_reg.vtx[em_idx_reg];
    assign normal_x    = nrm_reg[0];
    assign normal_y    = nrm_reg[1];
    assign normal_z    = nrm_reg[2];
    assign last_vertex = job_reg.eol && (em_idx_reg == job_reg.n - 2'd1);

    // edge magnitudes and prescale amounts
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_a[i] = ea_reg[i][32] ? 33'(-ea_reg[i]) : 33'(ea_reg[i]);
            mag_b[i] = eb_reg[i][32] ? 33'(-eb_reg[i]) : 33'(eb_reg[i]);
        end
        or_a = mag_a[0] | mag_a[1] | mag_a[2];
        or_b = mag_b[0] | mag_b[1] | mag_b[2];
        sh_a = or_a[32] ? 2'd3 : or_a[31] ? 2'd2 : or_a[30] ? 2'd1 : 2'd0;
        sh_b = or_b[32] ? 2'd3 : or_b[31] ? 2'd2 : or_b[30] ? 2'd1 : 2'd0;
    end

    // shared multiplier operand selection: cross terms, then squares
    always_comb
    begin
        op_a   = m_reg[0][29:0];
        op_b   = m_reg[0][29:0];
        op_neg = 1'b0;
        op_sel = 2'd0;
        if (state_reg == S_MUL)
        begin
            case (step_reg)
                3'd0:
                begin
                    op_a = ma_reg[1]; op_b = mb_reg[2];
                    op_neg = na_reg[1] ^ nb_reg[2]; op_sel = 2'd0;
                end
                3'd1:
                begin
                    op_a = ma_reg[2]; op_b = mb_reg[1];
                    op_neg = !(na_reg[2] ^ nb_reg[1]); op_sel = 2'd0;
                end
                3'd2:
                begin
                    op_a = ma_reg[2]; op_b = mb_reg[0];
                    op_neg = na_reg[2] ^ nb_reg[0]; op_sel = 2'd1;
                end
                3'd3:
                begin
                    op_a = ma_reg[0]; op_b = mb_reg[2];
                    op_neg = !(na_reg[0] ^ nb_reg[2]); op_sel = 2'd1;
                end
                3'd4:
                begin
                    op_a = ma_reg[0]; op_b = mb_reg[1];
                    op_neg = na_reg[0] ^ nb_reg[1]; op_sel = 2'd2;
                end
                default:
                begin
                    op_a = ma_reg[1]; op_b = mb_reg[0];
                    op_neg = !(na_reg[1] ^ nb_reg[0]); op_sel = 2'd2;
                end
            endcase
        end
        else
        begin
            case (step_reg)
                3'd0:    begin op_a = m_reg[0][29:0]; op_b = m_reg[0][29:0]; end
                3'd1:    begin op_a = m_reg[1][29:0]; op_b = m_reg[1][29:0]; end
                default: begin op_a = m_reg[2][29:0]; op_b = m_reg[2][29:0]; end
            endcase
        end
    end

    assign s_sum = s_reg + 62'(prod_reg);
    assign m_or  = m_reg[0] | m_reg[1] | m_reg[2];

    // square root step
    assign rt_bit    = 63'(1) << {rt_k_reg, 1'b0};
    assign rt_try    = rt_r_reg + rt_bit;
    assign rt_ge     = {1'b0, rt_rem_reg} >= rt_try;
    assign rt_r_next = rt_ge ? (rt_r_reg >> 1) + rt_bit : rt_r_reg >> 1;

    // restoring divide step
    assign dv_d      = 47'(len_reg) << dv_bit_reg;
    assign dv_ge     = dv_rem_reg >= dv_d;
    assign dv_q_next = dv_q_reg | (dv_ge ? 15'(1) << dv_bit_reg : 15'd0);
    assign dv_q16    = {1'b0, dv_q_next};

    always_ff @(posedge clk)
    begin
        prod_reg     <= 60'(op_a) * 60'(op_b);
        prod_neg_reg <= op_neg;
        prod_sel_reg <= op_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            emit_reg   <= 1'b0;
            em_idx_reg <= 2'd0;
            step_reg   <= 3'd0;
            rt_k_reg   <= 5'd0;
            dv_bit_reg <= 4'd0;
            comp_reg   <= 2'd0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (out_take)
                    begin
                        if (em_idx_reg == job_reg.n - 2'd1)
                        begin
                            emit_reg <= 1'b0;
                        end
                        else
                        begin
                            em_idx_reg <= em_idx_reg + 2'd1;
                        end
                    end
                    if (job_take)
                    begin
                        em_idx_reg <= 2'd0;
                        if (job.n == 2'(ffn_pkg::TRI_VERTS))
                        begin
                            state_reg <= S_EDGE;
                        end
                        else
                        begin
                            emit_reg <= 1'b1;
                        end
                    end
                end
                S_EDGE:
                begin
                    state_reg <= S_PRE;
                end
                S_PRE:
                begin
                    step_reg  <= 3'd0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (step_reg == 3'd6)
                    begin
                        state_reg <= S_ABS;
                    end
                    step_reg <= (step_reg == 3'd6) ? 3'd0 : step_reg + 3'd1;
                end
                S_ABS:
                begin
                    if (c_reg[0] == 63'sd0 && c_reg[1] == 63'sd0 && c_reg[2] == 63'sd0)
                    begin
                        state_reg <= S_IDLE;
                        emit_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (m_or[61:30] == 32'd0 && m_or[29])
                    begin
                        step_reg  <= 3'd0;
                        state_reg <= S_SQR;
                    end
                end
                S_SQR:
                begin
                    if (step_reg == 3'd3)
                    begin
                        rt_k_reg  <= 5'd31;
                        state_reg <= S_ROOT;
                    end
                    step_reg <= step_reg + 3'd1;
                end
                S_ROOT:
                begin
                    rt_k_reg <= rt_k_reg - 5'd1;
                    if (rt_k_reg == 5'd0)
                    begin
                        comp_reg   <= 2'd0;
                        dv_bit_reg <= 4'd15;
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (dv_bit_reg == 4'd15)
                    begin
                        dv_bit_reg <= 4'd14;
                    end
                    else if (dv_bit_reg == 4'd0)
                    begin
                        dv_bit_reg <= 4'd15;
                        comp_reg   <= comp_reg + 2'd1;
                        if (comp_reg == 2'd2)
                        begin
                            state_reg <= S_IDLE;
                            emit_reg  <= 1'b1;
                        end
                    end
                    else
                    begin
                        dv_bit_reg <= dv_bit_reg - 4'd1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (job_take)
                begin
                    job_reg <= job;
                    for (int i = 0; i < 3; i++)
                    begin
                        nrm_reg[i] <= 16'sd0;
                    end
                end
            end
            S_EDGE:
            begin
                ea_reg[0] <= {job_reg.vtx[1].pos_x[31], job_reg.vtx[1].pos_x}
                           - {job_reg.vtx[0].pos_x[31], job_reg.vtx[0].pos_x};
                ea_reg[1] <= {job_reg.vtx[1].pos_y[31], job_reg.vtx[1].pos_y}
                           - {job_reg.vtx[0].pos_y[31], job_reg.vtx[0].pos_y};
                ea_reg[2] <= {job_reg.vtx[1].pos_z[31], job_reg.vtx[1].pos_z}
                           - {job_reg.vtx[0].pos_z[31], job_reg.vtx[0].pos_z};
                eb_reg[0] <= {job_reg.vtx[2].pos_x[31], job_reg.vtx[2].pos_x}
                           - {job_reg.vtx[0].pos_x[31], job_reg.vtx[0].pos_x};
                eb_reg[1] <= {job_reg.vtx[2].pos_y[31], job_reg.vtx[2].pos_y}
                           - {job_reg.vtx[0].pos_y[31], job_reg.vtx[0].pos_y};
                eb_reg[2] <= {job_reg.vtx[2].pos_z[31], job_reg.vtx[2].pos_z}
                           - {job_reg.vtx[0].pos_z[31], job_reg.vtx[0].pos_z};
                for (int i = 0; i < 3; i++)
                begin
                    c_reg[i] <= 63'sd0;
                end
            end
            S_PRE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ma_reg[i] <= 30'(mag_a[i] >> sh_a);
                    mb_reg[i] <= 30'(mag_b[i] >> sh_b);
                    na_reg[i] <= ea_reg[i][32];
                    nb_reg[i] <= eb_reg[i][32];
                end
            end
            S_MUL:
            begin
                if (step_reg != 3'd0)
                begin
                    c_reg[prod_sel_reg] <= prod_neg_reg
                        ? c_reg[prod_sel_reg] - $signed({3'b000, prod_reg})
                        : c_reg[prod_sel_reg] + $signed({3'b000, prod_reg});
                end
            end
            S_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m_reg[i] <= c_reg[i][62] ? 62'(-c_reg[i]) : 62'(c_reg[i]);
                    cn_reg[i] <= c_reg[i][62];
                end
            end
            S_NORM:
            begin
                s_reg <= 62'd0;
                for (int i = 0; i < 3; i++)
                begin
                    if (m_or[61:38] != 24'd0)
                    begin
                        m_reg[i] <= m_reg[i] >> 8;
                    end
                    else if (m_or[61:30] != 32'd0)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                    else if (m_or[29:21] == 9'd0)
                    begin
                        m_reg[i] <= m_reg[i] << 8;
                    end
                    else if (!m_or[29])
                    begin
                        m_reg[i] <= m_reg[i] << 1;
                    end
                end
            end
            S_SQR:
            begin
                if (step_reg != 3'd0)
                begin
                    s_reg <= s_sum;
                end
                if (step_reg == 3'd3)
                begin
                    rt_rem_reg <= s_sum;
                    rt_r_reg   <= 63'd0;
                end
            end
            S_ROOT:
            begin
                rt_r_reg <= rt_r_next;
                if (rt_ge)
                begin
                    rt_rem_reg <= rt_rem_reg - rt_try[61:0];
                end
                if (rt_k_reg == 5'd0)
                begin
                    len_reg <= rt_r_next[31:0];
                end
            end
            S_DIV:
            begin
                if (dv_bit_reg == 4'd15)
                begin
                    dv_rem_reg <= 47'({m_reg[comp_reg][29:0], 14'd0}) + 47'(len_reg >> 1);
                    dv_q_reg   <= 15'd0;
                end
                else
                begin
                    dv_q_reg <= dv_q_next;
                    if (dv_ge)
                    begin
                        dv_rem_reg <= dv_rem_reg - dv_d;
                    end
                    if (dv_bit_reg == 4'd0)
                    begin
                        nrm_reg[comp_reg] <= cn_reg[comp_reg] ? -$signed(dv_q16)
                                                              : $signed(dv_q16);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // emission index stays inside the job
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_reg |-> (em_idx_reg < job_reg.n))
        else $error("emit index past job size");

    // a new job is never taken while vertices are still being emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        job_take |-> !emit_reg)
        else $error("job taken during emission");

    // squares only start on a normalized cross product
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQR) |-> (m_or[61:30] == 32'd0 && m_or[29]))
        else $error("cross product not normalized before squaring");

    // divide always starts with a root of at least 2^29
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (len_reg[31:29] != 3'd0))
        else $error("length below normalized range");

endmodule

// File: design/flat_face_normal_generator_core.sv
// ----------------------------------------------------------------------------
// flat_face_normal_generator_core
// flat-shading face normal generator: groups vertices into triangles and
// tags each vertex with the unit face normal of its triangle
// ----------------------------------------------------------------------------
// vertices enter one per beat unless in_stall holds them; every third vertex
// closes a triangle whose normal cross(v1 - v0, v2 - v0) is scaled to unit
// length in signed q1.14 and attached to all three vertices, which then leave
// one per beat in order unless out_stall holds them. when a list ends with one
// or two vertices left over they leave with a zero normal, and a degenerate
// triangle also gets a zero normal. the front holds the first two vertices of
// a triangle until the third arrives; the back end then runs the shared 30x30
// multiplier on the cross terms, normalizes, forms the squares, takes the
// bit-pair square root and does the three 15-bit restoring divides before
// emission, and takes no new job until that is done. leftover groups skip the
// datapath and go straight to emission. a two-entry job queue lets the input
// keep filling while the back end works or waits on out_stall.
// ----------------------------------------------------------------------------
module flat_face_normal_generator_core
(
    input  logic               clk,
    input  logic               rst_n,

    // vertex input beat
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [31:0]        color_word,
    input  logic [31:0]        tex_u,
    input  logic [31:0]        tex_v,
    input  logic               end_of_list,

    // vertex output beat
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [31:0]        out_color,
    output logic [31:0]        out_u,
    output logic [31:0]        out_v,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic               last_vertex
);

    ffn_pkg::vtx_t cur_vtx;
    ffn_pkg::vtx_t out_vtx;
    ffn_pkg::job_t push_job;
    ffn_pkg::job_t pop_job;
    logic          push_valid;
    logic          push_ready;
    logic          pop_valid;
    logic          pop_take;

    // pack incoming vertex
    always_comb
    begin
        cur_vtx.pos_x = pos_x;
        cur_vtx.pos_y = pos_y;
        cur_vtx.pos_z = pos_z;
        cur_vtx.color = color_word;
        cur_vtx.u     = tex_u;
        cur_vtx.v     = tex_v;
    end

    // front: hold vertices until a triangle or the list end
    ffn_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cur         (cur_vtx),
        .end_of_list (end_of_list),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job)
    );

    // decoupling queue
    ffn_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_take   (pop_take),
        .pop_job    (pop_job)
    );

    // back: normal computation and emission
    ffn_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (pop_valid),
        .job_take    (pop_take),
        .job         (pop_job),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_vtx     (out_vtx),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .last_vertex (last_vertex)
    );

    // unpack outgoing vertex
    assign out_x     = out_vtx.pos_x;
    assign out_y     = out_vtx.pos_y;
    assign out_z     = out_vtx.pos_z;
    assign out_color = out_vtx.color;
    assign out_u     = out_vtx.u;
    assign out_v     = out_vtx.v;

endmodule
